// File: rtl/nfza_pkg.sv
// nfza_pkg: shared constants and codes of the next-fit zone allocator.
// Depends on nothing; used by the allocator core and its testbench.
package nfza_pkg;

    localparam int ZONE_UNITS_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 32;
    localparam int UNIT_BYTES       = 8;
    localparam int UNIT_SHIFT       = 3;

    localparam logic [15:0] ZONE_BYTES_RST  = 16'd32768;
    localparam logic [10:0] SPLIT_THR_RST   = 11'd64;

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_RESIZE = 2'd2;
    localparam logic [1:0] MODE_REINIT = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_NULL    = 2'd2;
    localparam logic [1:0] ST_FREED   = 2'd3;

    localparam logic CFG_ZONE_BYTES = 1'b0;
    localparam logic CFG_SPLIT_THR  = 1'b1;

endpackage

// File: rtl/next_fit_zone_allocator_core.sv
// next_fit_zone_allocator_core: top level of the next-fit zone allocator.
// Depends on nfza_pkg and nfza_ram.
//
// One item is handled at a time. The block table (size, used flag, previous
// start per block start unit) lives in one RAM with a registered read; each
// block header visited goes through read issue, data return and check.
// Allocate walks from the rover, visiting blocks and then writing any split;
// free and pointer checks walk from block 0 to the pointer, then do the
// merge reads and writes. Reinitialise and the first item after reset first
// write the initial block. The result sits in an output register, and the
// next item is accepted as soon as it has been handed over.
module next_fit_zone_allocator_core #(
    parameter int ZONE_UNITS   = nfza_pkg::ZONE_UNITS_DEF,
    parameter int HEADER_BYTES = nfza_pkg::HEADER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_request_bytes,
    input  logic        i_pointer_valid,
    input  logic [14:0] i_pointer_offset,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_result_valid,
    output logic [14:0] o_result_offset,
    output logic [15:0] o_copy_bytes
);
    localparam int AW = $clog2(ZONE_UNITS);
    localparam int SW = AW + 1;          // sizes and starts up to ZONE_UNITS
    localparam int EW = 2 * SW + 1;      // RAM entry: size, used, prev

    typedef logic [SW-1:0] t_u;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_DISPATCH,
        S_FL_RD, S_FL_WT, S_FL_CHK,
        S_AL_RD, S_AL_WT, S_AL_CHK, S_AL_SPL1, S_AL_SPL2, S_AL_USE,
        S_FR_RD, S_FR_WT, S_FR_P_RD, S_FR_P_WT, S_FR_P_WR,
        S_FR_N_RD, S_FR_N_WT, S_FR_N_WR, S_FR_NN_RD, S_FR_NN_WT, S_FR_NN_WR,
        S_DONE
    } t_state;

    // configuration registers
    logic [15:0] r_zone_bytes;
    logic [10:0] r_split_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_bytes <= nfza_pkg::ZONE_BYTES_RST;
            r_split_thr  <= nfza_pkg::SPLIT_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nfza_pkg::CFG_ZONE_BYTES: r_zone_bytes <= i_cfg_data;
                nfza_pkg::CFG_SPLIT_THR:  r_split_thr  <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // block table RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    nfza_ram #(.WIDTH(EW), .DEPTH(ZONE_UNITS)) u_tab (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    t_u  rd_size, rd_prev;
    logic rd_used;
    assign rd_size = ram_rdata[EW-1 -: SW];
    assign rd_used = ram_rdata[SW];
    assign rd_prev = ram_rdata[SW-1:0];

    // control and item registers
    t_state       r_state;
    logic         r_init_busy;
    t_u           r_zone_end, r_rover;
    logic [1:0]   r_mode;
    logic [15:0]  r_req;
    logic         r_pv;
    logic [14:0]  r_off;
    t_u           r_cur, r_tgt, r_s, r_b, r_p, r_n, r_need, r_sz, r_bsz;
    logic [SW:0]  r_cnt;
    logic         r_move;     // moving resize: free old block after alloc
    logic [15:0]  r_cap;
    logic [1:0]   r_status;
    logic         r_rv;
    logic [14:0]  r_roff;
    logic [15:0]  r_copy;
    logic         r_ovalid;

    // combinational helpers
    logic [19:0] zb_units;
    t_u          init_end;
    logic [16:0] req_adj, need_full;
    t_u          need_c;
    logic [15:0] d_off;
    logic        ptr_ok;
    t_u          ptr_s;
    t_u          cur_next, nb;
    logic [SW+2:0] extra_b;
    t_u          extra;
    logic [15:0] cap_c;
    logic [15:0] blk_bytes;

    always_comb begin
        zb_units = {7'd0, r_zone_bytes[15:nfza_pkg::UNIT_SHIFT]};
        if (zb_units > 20'(ZONE_UNITS)) begin
            init_end = t_u'(ZONE_UNITS);
        end else begin
            init_end = t_u'(zb_units);
        end
        req_adj   = (r_req == 16'd0) ? 17'd1 : {1'b0, r_req};
        need_full = (req_adj + 17'(HEADER_BYTES + nfza_pkg::UNIT_BYTES - 1))
                    >> nfza_pkg::UNIT_SHIFT;
        need_c    = (need_full > 17'(ZONE_UNITS)) ? t_u'(ZONE_UNITS) + t_u'(1)
                                                  : t_u'(need_full);
        d_off     = {1'b0, r_off} - 16'(HEADER_BYTES);
        ptr_s     = t_u'(d_off[15:nfza_pkg::UNIT_SHIFT]);
        ptr_ok    = r_pv && ({1'b0, r_off} >= 16'(HEADER_BYTES))
                    && (d_off[nfza_pkg::UNIT_SHIFT-1:0] == '0)
                    && ({3'd0, d_off[15:nfza_pkg::UNIT_SHIFT]} < 16'(r_zone_end));
        cur_next  = r_cur + rd_size;
        nb        = r_cur + r_need;
        extra     = rd_size - r_need;
        extra_b   = {extra, 3'b000};
        blk_bytes = 16'({rd_size, 3'b000});
        cap_c     = (blk_bytes > 16'(HEADER_BYTES)) ? blk_bytes - 16'(HEADER_BYTES)
                                                    : 16'd0;
    end

    // RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = AW'(r_cur);
        ram_wdata = '0;
        ram_raddr = AW'(r_cur);
        case (r_state)
            S_INIT: begin
                ram_we    = (init_end != '0);
                ram_waddr = '0;
                ram_wdata = {init_end, 1'b0, t_u'(0)};
            end
            S_FL_RD, S_AL_RD: ram_raddr = AW'(r_cur);
            S_AL_SPL1: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(nb);
                ram_wdata = {r_sz - r_need, 1'b0, r_cur};
                ram_raddr = AW'(r_cur + r_sz);
            end
            S_AL_SPL2: begin
                // prev link of the block after the split remainder
                ram_we    = (r_cur + r_sz) < r_zone_end;
                ram_waddr = AW'(r_cur + r_sz);
                ram_wdata = {rd_size, rd_used, r_cur + r_need};
            end
            S_AL_USE: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_cur);
                ram_wdata = {r_sz, 1'b1, r_p};
            end
            S_FR_RD: ram_raddr = AW'(r_s);
            S_FR_WT: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_s);
                ram_wdata = {rd_size, 1'b0, rd_prev};
            end
            S_FR_P_RD: ram_raddr = AW'(r_p);
            S_FR_P_WR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_p);
                ram_wdata = {r_bsz, 1'b0, r_cur};
            end
            // keep the read address on the right neighbour until its write
            S_FR_N_RD, S_FR_N_WT: ram_raddr = AW'(r_n);
            S_FR_N_WR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_b);
                ram_wdata = {r_bsz, 1'b0, r_cur};
            end
            S_FR_NN_RD, S_FR_NN_WT: ram_raddr = AW'(r_n);
            S_FR_NN_WR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_n);
                ram_wdata = {rd_size, rd_used, r_b};
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_init_busy <= 1'b1;
            r_zone_end  <= '0;
            r_rover     <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_mode   <= i_mode;
                        r_req    <= i_request_bytes;
                        r_pv     <= i_pointer_valid;
                        r_off    <= i_pointer_offset;
                        r_status <= nfza_pkg::ST_OK;
                        r_rv     <= 1'b0;
                        r_roff   <= '0;
                        r_copy   <= '0;
                        r_move   <= 1'b0;
                        r_state  <= (r_init_busy || i_mode == nfza_pkg::MODE_REINIT)
                                    ? S_INIT : S_DISPATCH;
                    end
                end
                S_INIT: begin
                    r_zone_end  <= init_end;
                    r_rover     <= '0;
                    r_init_busy <= 1'b0;
                    r_state     <= (r_mode == nfza_pkg::MODE_REINIT) ? S_DONE
                                                                     : S_DISPATCH;
                end
                S_DISPATCH: begin
                    r_need <= need_c;
                    r_tgt  <= ptr_s;
                    r_cnt  <= '0;
                    if (r_mode == nfza_pkg::MODE_ALLOC ||
                        (r_mode == nfza_pkg::MODE_RESIZE && r_req != 16'd0 && !r_pv)) begin
                        if (r_zone_end == '0) begin
                            r_status <= nfza_pkg::ST_NOSPACE;
                            r_state  <= S_DONE;
                        end else begin
                            r_cur   <= (r_rover < r_zone_end) ? r_rover : '0;
                            r_state <= S_AL_RD;
                        end
                    end else if (!r_pv) begin
                        r_status <= nfza_pkg::ST_NULL;
                        r_state  <= S_DONE;
                    end else if (!ptr_ok) begin
                        r_status <= nfza_pkg::ST_FREED;
                        r_state  <= S_DONE;
                    end else begin
                        r_cur   <= '0;
                        r_state <= S_FL_RD;
                    end
                end
                // walk from block 0 to the pointer
                S_FL_RD: r_state <= S_FL_WT;
                S_FL_WT: r_state <= S_FL_CHK;
                S_FL_CHK: begin
                    if (r_cur == r_tgt) begin
                        if (!rd_used) begin
                            r_status <= nfza_pkg::ST_FREED;
                            r_state  <= S_DONE;
                        end else if (r_mode == nfza_pkg::MODE_FREE || r_req == 16'd0) begin
                            r_s     <= r_cur;
                            r_state <= S_FR_RD;
                        end else if ({1'b0, r_req} <= {1'b0, cap_c}) begin
                            r_rv    <= 1'b1;
                            r_roff  <= r_off;
                            r_state <= S_DONE;
                        end else begin
                            r_s     <= r_cur;
                            r_cap   <= cap_c;
                            r_move  <= 1'b1;
                            r_cnt   <= '0;
                            r_cur   <= (r_rover < r_zone_end) ? r_rover : '0;
                            r_state <= S_AL_RD;
                        end
                    end else if (r_cur > r_tgt || rd_size == '0
                                 || r_cnt > (SW+1)'(ZONE_UNITS)) begin
                        r_status <= nfza_pkg::ST_FREED;
                        r_state  <= S_DONE;
                    end else begin
                        r_cur   <= cur_next;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_FL_RD;
                    end
                end
                // next-fit search
                S_AL_RD: r_state <= S_AL_WT;
                S_AL_WT: r_state <= S_AL_CHK;
                S_AL_CHK: begin
                    if (!rd_used && rd_size >= r_need) begin
                        r_p  <= rd_prev;
                        if (extra_b > (SW+3)'(r_split_thr)) begin
                            r_sz    <= rd_size;
                            r_state <= S_AL_SPL1;
                        end else begin
                            r_sz    <= rd_size;
                            r_state <= S_AL_USE;
                        end
                    end else if (rd_size == '0 || r_cnt > (SW+1)'(ZONE_UNITS)) begin
                        r_status <= nfza_pkg::ST_NOSPACE;
                        r_state  <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        if ((cur_next >= r_zone_end ? t_u'(0) : cur_next) == r_rover) begin
                            r_status <= nfza_pkg::ST_NOSPACE;
                            r_state  <= S_DONE;
                        end else begin
                            r_cur   <= (cur_next >= r_zone_end) ? t_u'(0) : cur_next;
                            r_state <= S_AL_RD;
                        end
                    end
                end
                S_AL_SPL1: r_state <= S_AL_SPL2;
                S_AL_SPL2: begin
                    r_sz    <= r_need;
                    r_state <= S_AL_USE;
                end
                S_AL_USE: begin
                    r_rover <= ((r_cur + r_sz) < r_zone_end) ? r_cur + r_sz : '0;
                    r_rv    <= 1'b1;
                    r_roff  <= 15'({r_cur, 3'b000} + (SW+3)'(HEADER_BYTES));
                    if (r_move) begin
                        r_copy  <= r_cap;
                        r_state <= S_FR_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                // free and merge
                S_FR_RD: r_state <= S_FR_WT;
                S_FR_WT: begin
                    r_bsz <= rd_size;
                    r_p   <= rd_prev;
                    r_b   <= r_s;
                    r_cur <= rd_prev;   // prev link carried into merged writes
                    if (r_s != '0 && rd_prev < r_zone_end) begin
                        r_state <= S_FR_P_RD;
                    end else begin
                        r_n     <= r_s + rd_size;
                        r_state <= S_FR_N_RD;
                    end
                end
                S_FR_P_RD: r_state <= S_FR_P_WT;
                S_FR_P_WT: begin
                    if (!rd_used) begin
                        r_bsz   <= rd_size + r_bsz;
                        r_cur   <= rd_prev;
                        r_state <= S_FR_P_WR;
                    end else begin
                        r_n     <= r_s + r_bsz;
                        r_state <= S_FR_N_RD;
                    end
                end
                S_FR_P_WR: begin
                    // left merge done; fix link after and move on
                    if (r_rover == r_s) begin
                        r_rover <= r_p;
                    end
                    r_b     <= r_p;
                    r_n     <= r_p + r_bsz;
                    r_state <= S_FR_N_RD;
                end
                S_FR_N_RD: begin
                    if (r_n < r_zone_end) begin
                        r_state <= S_FR_N_WT;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_FR_N_WT: begin
                    if (!rd_used) begin
                        if (r_rover == r_n) begin
                            r_rover <= r_b;
                        end
                        r_bsz   <= r_bsz + rd_size;
                        r_state <= S_FR_N_WR;
                    end else begin
                        r_state <= S_FR_NN_WT;   // rd holds block after b
                    end
                end
                S_FR_N_WR: begin
                    r_n     <= r_b + r_bsz;
                    r_state <= S_FR_NN_RD;
                end
                S_FR_NN_RD: begin
                    if (r_n < r_zone_end) begin
                        r_state <= S_FR_NN_WT;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_FR_NN_WT: r_state <= S_FR_NN_WR;
                S_FR_NN_WR: r_state <= S_DONE;
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_status;
    assign o_result_valid  = r_rv;
    assign o_result_offset = r_rv ? r_roff : 15'd0;
    assign o_copy_bytes    = r_copy;
endmodule

// File: rtl/nfza_ram.sv
// nfza_ram: generic single-port-write, single-port-read RAM, registered read.
// Depends on nothing.
module nfza_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write, then registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: test/next_fit_zone_allocator_core_tb.sv
// Self-checking testbench of next_fit_zone_allocator_core: a scoreboard class
// predicts each allocator result and checks the output stream in order.
// Depends on nfza_pkg and the RTL of the allocator.
module next_fit_zone_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNITS  = nfza_pkg::ZONE_UNITS_DEF;
    localparam int HDR    = nfza_pkg::HEADER_BYTES_DEF;
    localparam int UB     = nfza_pkg::UNIT_BYTES;
    localparam int LIMIT  = 20000000;
    localparam int NRAND  = 230;

    typedef struct {
        logic [1:0]  status;
        logic        rvalid;
        logic [14:0] roffset;
        logic [15:0] copy;
    } t_zone_answer;

    // Zone bookkeeping and the queue of answers still owed by the block
    class zone_scoreboard;
        bit [12:0]    blk_size [UNITS];
        bit           blk_used [UNITS];
        bit [12:0]    blk_prev [UNITS];
        int unsigned  rover, zone_end, zone_bytes, split_thr;
        bit           init_pending;
        int unsigned  last_ptr;
        int           errors;
        t_zone_answer answers[$];

        function new();
            zone_bytes = nfza_pkg::ZONE_BYTES_RST;
            split_thr = nfza_pkg::SPLIT_THR_RST;
            init_pending = 1;
            rover = 0;
            zone_end = 0;
            errors = 0;
            last_ptr = 0;
        endfunction

        function void set_config(logic idx, logic [15:0] data);
            if (idx == nfza_pkg::CFG_ZONE_BYTES) zone_bytes = data;
            else split_thr = data[10:0];
        endfunction

        function void rebuild();
            int unsigned e;
            e = zone_bytes / UB;
            if (e > UNITS) e = UNITS;
            zone_end = e;
            if (e > 0) begin
                blk_size[0] = 13'(e);
                blk_used[0] = 0;
                blk_prev[0] = 0;
            end
            rover = 0;
            init_pending = 0;
        endfunction

        // Map a payload offset to a used block start, walking from block 0
        function bit live_start(bit pv, int unsigned off, output int unsigned s);
            int unsigned d, c, n;
            c = 0;
            n = 0;
            s = 0;
            if (!pv || off < HDR) return 0;
            d = off - HDR;
            if (d % UB != 0) return 0;
            s = d / UB;
            if (s >= zone_end) return 0;
            while (c < s && n <= UNITS) begin
                if (blk_size[c] == 0) return 0;
                c += blk_size[c];
                n++;
            end
            return (c == s) && blk_used[s];
        endfunction

        // Next-fit search from the rover, one lap at most
        function bit take_block(int unsigned req, output int unsigned st);
            int unsigned need, cur, sz, extra, nb, nx;
            st = 0;
            if (zone_end == 0) return 0;
            if (req == 0) req = 1;
            need = (req + HDR + UB - 1) / UB;
            cur = rover < zone_end ? rover : 0;
            for (int n = 0; n <= UNITS; n++) begin
                sz = blk_size[cur];
                if (!blk_used[cur] && sz >= need) begin
                    extra = sz - need;
                    if (extra * UB > split_thr) begin
                        nb = cur + need;
                        blk_size[nb] = 13'(extra);
                        blk_used[nb] = 0;
                        blk_prev[nb] = 13'(cur);
                        if (nb + extra < zone_end) blk_prev[nb + extra] = 13'(nb);
                        blk_size[cur] = 13'(need);
                    end
                    blk_used[cur] = 1;
                    nx = cur + blk_size[cur];
                    rover = nx < zone_end ? nx : 0;
                    st = cur;
                    return 1;
                end
                if (sz == 0) return 0;
                cur += sz;
                if (cur >= zone_end) cur = 0;
                if (cur == rover) return 0;
            end
            return 0;
        endfunction

        // Release a block and merge with free neighbours on either side
        function void release_block(int unsigned s);
            int unsigned b, p, nx, n, nn;
            b = s;
            blk_used[s] = 0;
            if (s != 0) begin
                p = blk_prev[s];
                if (p < zone_end && !blk_used[p]) begin
                    nx = s + blk_size[s];
                    blk_size[p] += blk_size[s];
                    if (nx < zone_end) blk_prev[nx] = 13'(p);
                    if (rover == s) rover = p;
                    b = p;
                end
            end
            n = b + blk_size[b];
            if (n < zone_end && !blk_used[n]) begin
                if (rover == n) rover = b;
                blk_size[b] += blk_size[n];
                nn = b + blk_size[b];
                if (nn < zone_end) blk_prev[nn] = 13'(b);
            end
        endfunction

        // Predict the answer of one accepted request
        function void note_request(logic [1:0] mode, logic [15:0] req, logic pv,
                                   logic [14:0] off);
            t_zone_answer a;
            int unsigned s, ns, cap;
            a = '{nfza_pkg::ST_OK, 1'b0, 15'd0, 16'd0};
            if (init_pending) rebuild();
            if (mode == nfza_pkg::MODE_REINIT) begin
                rebuild();
            end else if (mode == nfza_pkg::MODE_ALLOC ||
                         (mode == nfza_pkg::MODE_RESIZE && req != 0 && !pv)) begin
                if (take_block(req, ns)) begin
                    a.rvalid = 1;
                    a.roffset = 15'(ns * UB + HDR);
                end else a.status = nfza_pkg::ST_NOSPACE;
            end else if (mode == nfza_pkg::MODE_FREE || req == 0) begin
                if (!pv) a.status = nfza_pkg::ST_NULL;
                else if (live_start(pv, off, s)) release_block(s);
                else a.status = nfza_pkg::ST_FREED;
            end else if (!live_start(pv, off, s)) begin
                a.status = nfza_pkg::ST_FREED;
            end else begin
                cap = blk_size[s] * UB;
                cap = cap > HDR ? cap - HDR : 0;
                if (req <= cap) begin
                    a.rvalid = 1;
                    a.roffset = off;
                end else if (take_block(req, ns)) begin
                    a.rvalid = 1;
                    a.roffset = 15'(ns * UB + HDR);
                    a.copy = 16'(cap);
                    release_block(s);
                end else a.status = nfza_pkg::ST_NOSPACE;
            end
            if (a.rvalid) last_ptr = a.roffset;
            answers.push_back(a);
        endfunction

        function void check_answer(logic [1:0] st, logic rv, logic [14:0] ro,
                                   logic [15:0] cp);
            t_zone_answer e;
            if (answers.size() == 0) begin
                $display("%0t: unexpected result status=%0d valid=%0d offset=%0d copy=%0d",
                         $time, st, rv, ro, cp);
                errors++;
                return;
            end
            e = answers.pop_front();
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (rv !== e.rvalid) begin
                $display("%0t: result_valid expected %0d actual %0d", $time, e.rvalid, rv);
                errors++;
            end
            if (ro !== e.roffset) begin
                $display("%0t: result_offset expected %0d actual %0d", $time, e.roffset, ro);
                errors++;
            end
            if (cp !== e.copy) begin
                $display("%0t: copy_bytes expected %0d actual %0d", $time, e.copy, cp);
                errors++;
            end
        endfunction

        // Pick the payload offset of a random used block, 0 if none
        function int unsigned pick_live();
            int unsigned c, q[$];
            c = 0;
            if (init_pending) return 0;
            while (c < zone_end && blk_size[c] != 0) begin
                if (blk_used[c]) q.push_back(c * UB + HDR);
                c += blk_size[c];
            end
            if (q.size() == 0) return 0;
            return q[$urandom_range(q.size() - 1)];
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic        i_cfg_index = 0;
    logic [15:0] i_cfg_data = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_mode = nfza_pkg::MODE_ALLOC;
    logic [15:0] i_request_bytes = 0;
    logic        i_pointer_valid = 0;
    logic [14:0] i_pointer_offset = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [1:0]  o_status;
    logic        o_result_valid;
    logic [14:0] o_result_offset;
    logic [15:0] o_copy_bytes;

    zone_scoreboard sb = new();
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold = 0;
    int cycle_count = 0;

    next_fit_zone_allocator_core dut (.*);

    always #1 i_clk = ~i_clk;

    // Receiver: random stalls plus a long hold-off; check every transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_answer(o_status, o_result_valid, o_result_offset, o_copy_bytes);
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one request and hold it until the transfer
    task automatic send_req(logic [1:0] mode, logic [15:0] req, logic pv,
                            logic [14:0] off);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_request_bytes <= req;
        i_pointer_valid <= pv;
        i_pointer_offset <= off;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(mode, req, pv, off);
    endtask

    // Drop valid and wait until every answer has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.answers.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_config(idx, data);
    endtask

    // Mostly well-formed traffic on live blocks, the rest random noise
    task automatic random_traffic(int count);
        int unsigned r, p;
        logic [15:0] sz;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            sz = 16'(($urandom_range(9) == 0) ? $urandom_range(65535)
                                              : $urandom_range(300));
            p = sb.pick_live();
            if (r < 40 || (r < 80 && p == 0))
                send_req(nfza_pkg::MODE_ALLOC, sz, 1'b1, 15'($urandom));
            else if (r < 65)
                send_req(nfza_pkg::MODE_FREE, 16'($urandom), 1'b1, 15'(p));
            else if (r < 80)
                send_req(nfza_pkg::MODE_RESIZE, sz, 1'b1, 15'(p));
            else if (r < 85)
                send_req(nfza_pkg::MODE_RESIZE, sz, 1'b0, 15'($urandom));
            else if (r < 87)
                send_req(nfza_pkg::MODE_REINIT, 16'($urandom), 1'($urandom),
                         15'($urandom));
            else
                send_req(2'($urandom_range(2)), 16'($urandom), 1'($urandom),
                         15'($urandom));
        end
    endtask

    initial begin
        int unsigned p;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: edge sizes, bad pointers, every resize path
        send_req(nfza_pkg::MODE_ALLOC, 16'd0, 1'b0, 15'd0);
        send_req(nfza_pkg::MODE_ALLOC, 16'hFFFF, 1'b0, 15'd0);
        send_req(nfza_pkg::MODE_ALLOC, 16'd100, 1'b0, 15'd0);
        p = sb.last_ptr;
        send_req(nfza_pkg::MODE_RESIZE, 16'd104, 1'b1, 15'(p));
        send_req(nfza_pkg::MODE_RESIZE, 16'd500, 1'b1, 15'(p));
        send_req(nfza_pkg::MODE_RESIZE, 16'hFFFF, 1'b1, 15'(sb.last_ptr));
        send_req(nfza_pkg::MODE_FREE, 16'd0, 1'b0, 15'd0);
        send_req(nfza_pkg::MODE_FREE, 16'd0, 1'b1, 15'd0);
        send_req(nfza_pkg::MODE_FREE, 16'd0, 1'b1, 15'd33);
        send_req(nfza_pkg::MODE_FREE, 16'd0, 1'b1, 15'h7FFF);
        send_req(nfza_pkg::MODE_FREE, 16'd0, 1'b1, 15'(p));
        send_req(nfza_pkg::MODE_RESIZE, 16'd8, 1'b1, 15'(p));
        send_req(nfza_pkg::MODE_RESIZE, 16'd0, 1'b0, 15'd0);
        send_req(nfza_pkg::MODE_RESIZE, 16'd40, 1'b0, 15'd0);
        send_req(nfza_pkg::MODE_RESIZE, 16'd0, 1'b1, 15'(sb.last_ptr));
        send_req(nfza_pkg::MODE_FREE, 16'd0, 1'b1, 15'(HDR));
        send_req(nfza_pkg::MODE_REINIT, 16'd0, 1'b0, 15'd0);
        drain();
        // Empty zone, then a 64-byte zone with no split threshold
        cfg_write(nfza_pkg::CFG_ZONE_BYTES, 16'd7);
        send_req(nfza_pkg::MODE_REINIT, 16'd0, 1'b0, 15'd0);
        send_req(nfza_pkg::MODE_ALLOC, 16'd1, 1'b0, 15'd0);
        send_req(nfza_pkg::MODE_FREE, 16'd0, 1'b1, 15'(HDR));
        drain();
        cfg_write(nfza_pkg::CFG_ZONE_BYTES, 16'd64);
        cfg_write(nfza_pkg::CFG_SPLIT_THR, 16'd0);
        send_req(nfza_pkg::MODE_REINIT, 16'd0, 1'b0, 15'd0);
        send_req(nfza_pkg::MODE_ALLOC, 16'd1, 1'b0, 15'd0);
        send_req(nfza_pkg::MODE_ALLOC, 16'd1, 1'b0, 15'd0);
        drain();

        // Phase one: clamped full zone, busy receiver, one long hold-off
        cfg_write(nfza_pkg::CFG_ZONE_BYTES, 16'hFFFF);
        cfg_write(nfza_pkg::CFG_SPLIT_THR, 16'd64);
        send_req(nfza_pkg::MODE_REINIT, 16'd0, 1'b0, 15'd0);
        tx_idle_pct = 34;
        rx_idle_pct = 60;
        random_traffic(NRAND / 2);
        rx_hold = 400;
        random_traffic(NRAND / 2);
        drain();

        // Phase two: small zone, largest threshold the register holds
        cfg_write(nfza_pkg::CFG_ZONE_BYTES, 16'd2048);
        cfg_write(nfza_pkg::CFG_SPLIT_THR, 16'd2047);
        send_req(nfza_pkg::MODE_REINIT, 16'd0, 1'b0, 15'd0);
        tx_idle_pct = 60;
        rx_idle_pct = 34;
        random_traffic(NRAND / 2);
        drain();
        cfg_write(nfza_pkg::CFG_SPLIT_THR, 16'd1024);
        random_traffic(NRAND / 2);
        drain();

        // Phase three: no idling, reset zone size, split threshold of 8
        cfg_write(nfza_pkg::CFG_ZONE_BYTES, 16'd32768);
        cfg_write(nfza_pkg::CFG_SPLIT_THR, 16'd8);
        send_req(nfza_pkg::MODE_REINIT, 16'd0, 1'b0, 15'd0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_traffic(NRAND);
        drain();

        if (sb.errors == 0 && sb.answers.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// File: next_fit_zone_allocator_core.f
rtl/nfza_pkg.sv
rtl/nfza_ram.sv
rtl/next_fit_zone_allocator_core.sv
test/next_fit_zone_allocator_core_tb.sv
